// File: rtl/ppu_pkg.sv
// Package for the projectile pool update block: sizes, codes, result record
// and the controller state type. No dependencies.
package ppu_pkg;

   localparam int POOL_SLOTS  = 64;
   localparam int MAX_RESULTS = 64;
   localparam int SLOT_W      = $clog2(POOL_SLOTS);
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
   localparam int LIFE_W      = 24;
   localparam int POS_W       = 32;
   localparam int DT_W        = 16;
   localparam int IDX_OUT_W   = 6;
   localparam int PROD_W      = POS_W + DT_W + 1;
   localparam int POSMEM_W    = LIFE_W + 3 * POS_W;
   localparam int VELMEM_W    = 3 * POS_W;

   localparam logic [LIFE_W-1:0] LIFE_RESET = 24'd327680;

   localparam logic CMD_SPAWN  = 1'b0;
   localparam logic CMD_TICK   = 1'b1;
   localparam logic KIND_SPAWN = 1'b0;
   localparam logic KIND_TICK  = 1'b1;

   typedef struct packed {
      logic                    kind;
      logic                    accepted;
      logic [IDX_OUT_W-1:0]    slot_index;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic                    last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SPAWN_SCAN,
      ST_SPAWN_RESP,
      ST_TICK_SCAN,
      ST_TICK_MUL,
      ST_TICK_ADD,
      ST_TICK_FLUSH
   } state_type;

endpackage

// File: rtl/ppu_if.sv
// Channel interfaces of the projectile pool update block: request, result
// and register write. Depends on ppu_pkg.
interface ppu_req_if;
   import ppu_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    command;
   logic signed [POS_W-1:0] spawn_pos_x;
   logic signed [POS_W-1:0] spawn_pos_y;
   logic signed [POS_W-1:0] spawn_pos_z;
   logic signed [POS_W-1:0] spawn_vel_x;
   logic signed [POS_W-1:0] spawn_vel_y;
   logic signed [POS_W-1:0] spawn_vel_z;
   logic [DT_W-1:0]         time_step;

   modport source (output valid, command, spawn_pos_x, spawn_pos_y, spawn_pos_z,
                   spawn_vel_x, spawn_vel_y, spawn_vel_z, time_step, input ready);
   modport sink   (input valid, command, spawn_pos_x, spawn_pos_y, spawn_pos_z,
                   spawn_vel_x, spawn_vel_y, spawn_vel_z, time_step, output ready);
endinterface

interface ppu_rsp_if;
   import ppu_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    kind;
   logic                    accepted;
   logic [IDX_OUT_W-1:0]    slot_index;
   logic signed [POS_W-1:0] out_pos_x;
   logic signed [POS_W-1:0] out_pos_y;
   logic signed [POS_W-1:0] out_pos_z;
   logic                    last;

   modport source (output valid, kind, accepted, slot_index, out_pos_x, out_pos_y,
                   out_pos_z, last, input ready);
   modport sink   (input valid, kind, accepted, slot_index, out_pos_x, out_pos_y,
                   out_pos_z, last, output ready);
endinterface

interface ppu_csr_if;
   import ppu_pkg::*;
   logic              valid;
   logic              ready;
   logic [LIFE_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// File: rtl/projectile_pool_update.sv
// Projectile pool update: top level with slot controller and result register.
// Depends on ppu_pkg, the ppu_*_if interfaces and ppu_ram.
//
// The block keeps POOL_SLOTS projectile slots. Lifetime and position of each
// slot live in one RAM, velocity in a second one; a live flag per slot sits
// in flip-flops and is cleared by reset, so the pool comes up empty with no
// clearing pass. A spawn request walks the live flags one slot per cycle from
// slot 0 and writes the first dead slot with the configured lifetime and the
// given position and velocity; its single result follows. A spawn looks at
// slots in order up to the first dead one, at most POOL_SLOTS of them.
// A tick request walks every slot once: a dead slot is passed over in the
// scan state, while a live slot goes through RAM read, multiply of velocity
// by time_step, and saturating add and write-back, one slot at a time over
// the single RAM read port. Results of a tick are held back by one slot, so
// the last one can be flagged without looking ahead; an empty pool gives one
// result with accepted low. One result register sits on the output: a
// waiting result stalls only the step that must hand over the next one. A
// new request is taken whenever the controller is idle. The lifetime
// register is written through the csr channel, which is always ready.
module projectile_pool_update (
   input  logic       clock,
   input  logic       reset,
   ppu_req_if.sink    req_chan,
   ppu_rsp_if.source  rsp_chan,
   ppu_csr_if.sink    csr_chan
);
   import ppu_pkg::*;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(POOL_SLOTS - 1);
   localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_RESULTS);

   // Position plus floor(prod / 2^16), clamped to the signed 32-bit range.
   // The sum overflows 32 bits when its top three bits disagree.
   function automatic logic signed [POS_W-1:0] advance(
      input logic signed [POS_W-1:0]  pos,
      input logic signed [PROD_W-1:0] prod
   );
      logic signed [POS_W+1:0] sum;
      sum = (POS_W+2)'(pos) + (POS_W+2)'($signed(prod[PROD_W-1:DT_W]));
      if (!sum[POS_W+1] && (sum[POS_W:POS_W-1] != 2'b00)) begin
         advance = {1'b0, {(POS_W-1){1'b1}}};
      end else if (sum[POS_W+1] && (sum[POS_W:POS_W-1] != 2'b11)) begin
         advance = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
         advance = sum[POS_W-1:0];
      end
   endfunction

   // Control state.
   state_type          state_ff, state_in;
   logic [POOL_SLOTS-1:0] live_ff, live_in;
   logic [SLOT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               pend_valid_ff, pend_valid_in;
   logic               hit_ff, hit_in;
   logic [LIFE_W-1:0]  lifetime_ff, lifetime_in;

   // Payload.
   logic signed [POS_W-1:0]  cap_px_ff, cap_py_ff, cap_pz_ff;
   logic signed [POS_W-1:0]  cap_vx_ff, cap_vy_ff, cap_vz_ff;
   logic [DT_W-1:0]          dt_ff;
   logic signed [PROD_W-1:0] prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [PROD_W-1:0] prod_x_in, prod_y_in, prod_z_in;
   logic signed [POS_W-1:0]  cur_px_ff, cur_py_ff, cur_pz_ff;
   logic [LIFE_W-1:0]        cur_life_ff;
   rsp_type                  rsp_data_ff, rsp_data_in;
   rsp_type                  pend_ff, pend_in;

   // RAM ports.
   logic                pos_wr_en, vel_wr_en, rd_en;
   logic [POSMEM_W-1:0] pos_wr_data, pos_rd_data;
   logic [VELMEM_W-1:0] vel_wr_data, vel_rd_data;

   // Values derived from the RAM words and the multiply stage.
   logic [LIFE_W-1:0]       rd_life;
   logic signed [POS_W-1:0] rd_px, rd_py, rd_pz;
   logic signed [POS_W-1:0] rd_vx, rd_vy, rd_vz;
   logic signed [POS_W-1:0] new_px, new_py, new_pz;
   logic [LIFE_W-1:0]       new_life;
   logic signed [DT_W:0]    dt_signed;
   logic                    out_free, req_take, enq, go;

   ppu_ram #(.WIDTH(POSMEM_W), .DEPTH(POOL_SLOTS)) u_pos_ram (
      .clock   (clock),
      .wr_en   (pos_wr_en),
      .wr_addr (idx_ff),
      .wr_data (pos_wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (pos_rd_data)
   );

   ppu_ram #(.WIDTH(VELMEM_W), .DEPTH(POOL_SLOTS)) u_vel_ram (
      .clock   (clock),
      .wr_en   (vel_wr_en),
      .wr_addr (idx_ff),
      .wr_data (vel_wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (vel_rd_data)
   );

   assign {rd_life, rd_px, rd_py, rd_pz} = pos_rd_data;
   assign {rd_vx, rd_vy, rd_vz}          = vel_rd_data;

   // Multiply stage: velocity times unsigned time step.
   assign dt_signed = $signed({1'b0, dt_ff});
   assign prod_x_in = rd_vx * dt_signed;
   assign prod_y_in = rd_vy * dt_signed;
   assign prod_z_in = rd_vz * dt_signed;

   // Add stage: saturating position update and lifetime countdown.
   assign new_px   = advance(cur_px_ff, prod_x_ff);
   assign new_py   = advance(cur_py_ff, prod_y_ff);
   assign new_pz   = advance(cur_pz_ff, prod_z_ff);
   assign new_life = (cur_life_ff > LIFE_W'(dt_ff)) ? cur_life_ff - LIFE_W'(dt_ff)
                                                     : '0;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   // Enqueue a tick report only while under the result limit; stall the add
   // stage when the held-back report cannot move to the output register.
   assign enq = (cnt_ff < MAX_CNT);
   assign go  = !(enq && pend_valid_ff && !out_free);

   always_comb begin
      state_in      = state_ff;
      live_in       = live_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      hit_in        = hit_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      lifetime_in   = csr_chan.valid ? csr_chan.data : lifetime_ff;
      pos_wr_en     = 1'b0;
      vel_wr_en     = 1'b0;
      rd_en         = 1'b0;
      pos_wr_data   = {lifetime_ff, cap_px_ff, cap_py_ff, cap_pz_ff};
      vel_wr_data   = {cap_vx_ff, cap_vy_ff, cap_vz_ff};

      unique case (state_ff)
         ST_IDLE: begin
            idx_in        = '0;
            cnt_in        = '0;
            pend_valid_in = 1'b0;
            if (req_take) begin
               state_in = (req_chan.command == CMD_SPAWN) ? ST_SPAWN_SCAN
                                                          : ST_TICK_SCAN;
            end
         end

         ST_SPAWN_SCAN: begin
            // Claim the first dead slot; a zero lifetime leaves it dead.
            if (!live_ff[idx_ff]) begin
               pos_wr_en       = 1'b1;
               vel_wr_en       = 1'b1;
               live_in[idx_ff] = (lifetime_ff != '0);
               hit_in          = 1'b1;
               state_in        = ST_SPAWN_RESP;
            end else if (idx_ff == LAST_SLOT) begin
               hit_in   = 1'b0;
               state_in = ST_SPAWN_RESP;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         ST_SPAWN_RESP: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in            = '0;
               rsp_data_in.kind       = KIND_SPAWN;
               rsp_data_in.accepted   = hit_ff;
               rsp_data_in.slot_index = hit_ff ? IDX_OUT_W'(idx_ff) : '0;
               rsp_data_in.last       = 1'b1;
               state_in               = ST_IDLE;
            end
         end

         ST_TICK_SCAN: begin
            if (live_ff[idx_ff]) begin
               rd_en    = 1'b1;
               state_in = ST_TICK_MUL;
            end else if (idx_ff == LAST_SLOT) begin
               state_in = ST_TICK_FLUSH;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         ST_TICK_MUL: begin
            state_in = ST_TICK_ADD;
         end

         ST_TICK_ADD: begin
            if (go) begin
               pos_wr_en       = 1'b1;
               pos_wr_data     = {new_life, new_px, new_py, new_pz};
               live_in[idx_ff] = (new_life != '0);
               if (enq) begin
                  // Release the held-back report, hold this one.
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = pend_ff;
                  end
                  pend_valid_in      = 1'b1;
                  pend_in.kind       = KIND_TICK;
                  pend_in.accepted   = 1'b1;
                  pend_in.slot_index = IDX_OUT_W'(idx_ff);
                  pend_in.pos_x      = new_px;
                  pend_in.pos_y      = new_py;
                  pend_in.pos_z      = new_pz;
                  pend_in.last       = 1'b0;
                  cnt_in             = cnt_ff + 1'b1;
               end
               if (idx_ff == LAST_SLOT) begin
                  state_in = ST_TICK_FLUSH;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_TICK_SCAN;
               end
            end
         end

         ST_TICK_FLUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (pend_valid_ff) begin
                  rsp_data_in      = pend_ff;
                  rsp_data_in.last = 1'b1;
               end else begin
                  rsp_data_in      = '0;
                  rsp_data_in.kind = KIND_TICK;
                  rsp_data_in.last = 1'b1;
               end
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         live_ff       <= '0;
         idx_ff        <= '0;
         cnt_ff        <= '0;
         hit_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         lifetime_ff   <= LIFE_RESET;
      end else begin
         state_ff      <= state_in;
         live_ff       <= live_in;
         idx_ff        <= idx_in;
         cnt_ff        <= cnt_in;
         hit_ff        <= hit_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
         lifetime_ff   <= lifetime_in;
      end
   end

   // Payload registers: capture the request, then the multiply stage.
   always_ff @(posedge clock) begin
      if (req_take) begin
         cap_px_ff <= req_chan.spawn_pos_x;
         cap_py_ff <= req_chan.spawn_pos_y;
         cap_pz_ff <= req_chan.spawn_pos_z;
         cap_vx_ff <= req_chan.spawn_vel_x;
         cap_vy_ff <= req_chan.spawn_vel_y;
         cap_vz_ff <= req_chan.spawn_vel_z;
         dt_ff     <= req_chan.time_step;
      end
      if (state_ff == ST_TICK_MUL) begin
         prod_x_ff   <= prod_x_in;
         prod_y_ff   <= prod_y_in;
         prod_z_ff   <= prod_z_in;
         cur_px_ff   <= rd_px;
         cur_py_ff   <= rd_py;
         cur_pz_ff   <= rd_pz;
         cur_life_ff <= rd_life;
      end
      rsp_data_ff <= rsp_data_in;
      pend_ff     <= pend_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.kind       = rsp_data_ff.kind;
   assign rsp_chan.accepted   = rsp_data_ff.accepted;
   assign rsp_chan.slot_index = rsp_data_ff.slot_index;
   assign rsp_chan.out_pos_x  = rsp_data_ff.pos_x;
   assign rsp_chan.out_pos_y  = rsp_data_ff.pos_y;
   assign rsp_chan.out_pos_z  = rsp_data_ff.pos_z;
   assign rsp_chan.last       = rsp_data_ff.last;

endmodule

// File: rtl/ppu_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ppu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: bench/projectile_pool_update_test.sv
// Self-checking bench for projectile_pool_update: spawn and tick requests,
// a lifetime register, and a predictor of the slot pool. Depends on ppu_pkg,
// the ppu_*_if interfaces and the projectile_pool_update RTL.
module projectile_pool_update_test;
   import ppu_pkg::*;

   // Count idle cycles only while nothing moves on any channel. A full spawn
   // scan, a tick walking a mostly dead pool, the longest sender gap and the
   // longest receiver stall together stay far below this.
   localparam int WATCHDOG_LIMIT   = 4000;
   // Let a tick over a full pool finish before the final verdict.
   localparam int END_PAUSE        = 3 * POOL_SLOTS + 16;
   localparam int RANDOM_PHASES    = 4;
   localparam int RANDOM_PER_PHASE = 45;
   localparam longint POS_MAX      = 64'sd2147483647;
   localparam longint POS_MIN      = -64'sd2147483648;

   typedef struct packed {
      logic                    command;
      logic signed [POS_W-1:0] px;
      logic signed [POS_W-1:0] py;
      logic signed [POS_W-1:0] pz;
      logic signed [POS_W-1:0] vx;
      logic signed [POS_W-1:0] vy;
      logic signed [POS_W-1:0] vz;
      logic [DT_W-1:0]         dt;
   } pool_request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ppu_req_if req_chan ();
   ppu_rsp_if rsp_chan ();
   ppu_csr_if csr_chan ();

   projectile_pool_update uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the pool and the lifetime register.
   logic [LIFE_W-1:0]       lifetime_setting;
   logic [LIFE_W-1:0]       life_left [POOL_SLOTS];
   logic signed [POS_W-1:0] pos_x_of  [POOL_SLOTS];
   logic signed [POS_W-1:0] pos_y_of  [POOL_SLOTS];
   logic signed [POS_W-1:0] pos_z_of  [POOL_SLOTS];
   logic signed [POS_W-1:0] vel_x_of  [POOL_SLOTS];
   logic signed [POS_W-1:0] vel_y_of  [POOL_SLOTS];
   logic signed [POS_W-1:0] vel_z_of  [POOL_SLOTS];

   rsp_type pending_results [$];
   int      mismatch_count = 0;
   int      idle_cycles    = 0;
   int      stall_left     = 0;
   bit      steady_flow    = 1'b0;

   // ---------------------------------------------------------------------
   // Pool predictor
   // ---------------------------------------------------------------------

   // Move one axis by vel * dt, floor the Q16.16 product, saturate to 32 bits.
   function automatic logic signed [POS_W-1:0] advance_axis(
      input logic signed [POS_W-1:0] pos,
      input logic signed [POS_W-1:0] vel,
      input logic [DT_W-1:0]         dt);
      longint prod;
      longint moved;
      prod  = longint'(vel) * longint'(dt);
      moved = longint'(pos) + (prod >>> 16);
      if (moved > POS_MAX) moved = POS_MAX;
      if (moved < POS_MIN) moved = POS_MIN;
      return moved[POS_W-1:0];
   endfunction

   function automatic int live_count();
      int n;
      n = 0;
      for (int i = 0; i < POOL_SLOTS; i++)
         if (life_left[i] != '0) n++;
      return n;
   endfunction

   // Store into the lowest dead slot; a full pool leaves everything as is.
   task automatic spawn_into_pool(input pool_request_type item);
      rsp_type answer;
      bit      found;
      answer = '0;
      found  = 1'b0;
      for (int i = 0; i < POOL_SLOTS; i++) begin
         if (!found && life_left[i] == '0) begin
            found       = 1'b1;
            life_left[i] = lifetime_setting;
            pos_x_of[i] = item.px;
            pos_y_of[i] = item.py;
            pos_z_of[i] = item.pz;
            vel_x_of[i] = item.vx;
            vel_y_of[i] = item.vy;
            vel_z_of[i] = item.vz;
            answer.slot_index = IDX_OUT_W'(i);
         end
      end
      answer.kind     = KIND_SPAWN;
      answer.accepted = found;
      answer.last     = 1'b1;
      pending_results.push_back(answer);
   endtask

   // Advance every live slot; report up to MAX_RESULTS of them in slot order.
   // Hold each report back by one so the final one can carry last.
   task automatic tick_pool(input logic [DT_W-1:0] dt);
      rsp_type held;
      bit      have_held;
      int      reported;
      held      = '0;
      have_held = 1'b0;
      reported  = 0;
      for (int i = 0; i < POOL_SLOTS; i++) begin
         if (life_left[i] != '0) begin
            life_left[i] = (life_left[i] > dt) ? life_left[i] - dt : '0;
            pos_x_of[i] = advance_axis(pos_x_of[i], vel_x_of[i], dt);
            pos_y_of[i] = advance_axis(pos_y_of[i], vel_y_of[i], dt);
            pos_z_of[i] = advance_axis(pos_z_of[i], vel_z_of[i], dt);
            if (reported < MAX_RESULTS) begin
               if (have_held) pending_results.push_back(held);
               held            = '0;
               held.kind       = KIND_TICK;
               held.accepted   = 1'b1;
               held.slot_index = IDX_OUT_W'(i);
               held.pos_x      = pos_x_of[i];
               held.pos_y      = pos_y_of[i];
               held.pos_z      = pos_z_of[i];
               have_held       = 1'b1;
               reported++;
            end
         end
      end
      // An empty pool still answers once, with no valid position.
      if (!have_held) begin
         held      = '0;
         held.kind = KIND_TICK;
      end
      held.last = 1'b1;
      pending_results.push_back(held);
   endtask

   // ---------------------------------------------------------------------
   // Random choices
   // ---------------------------------------------------------------------

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap();
      int unsigned roll;
      if (steady_flow) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Extremes, full-range noise, and small values that keep positions moving.
   function automatic logic signed [POS_W-1:0] pick_coord();
      int unsigned roll;
      int          near_zero;
      roll      = $urandom_range(0, 9);
      near_zero = $urandom_range(0, 32'h0020_0000);
      case (roll)
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2, 3, 4: return $urandom;
         default: return near_zero - 32'sh0010_0000;
      endcase
   endfunction

   function automatic logic [DT_W-1:0] pick_step();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      case (roll)
         0:       return '0;
         1:       return 16'hFFFF;
         2:       return DT_W'($urandom_range(0, 16'hFFFF));
         default: return DT_W'($urandom_range(1, 16'h2000));
      endcase
   endfunction

   function automatic pool_request_type make_spawn(
      input logic signed [POS_W-1:0] px, py, pz, vx, vy, vz);
      pool_request_type item;
      item.command = CMD_SPAWN;
      item.px = px;
      item.py = py;
      item.pz = pz;
      item.vx = vx;
      item.vy = vy;
      item.vz = vz;
      item.dt = DT_W'($urandom_range(0, 16'hFFFF));
      return item;
   endfunction

   function automatic pool_request_type random_spawn();
      return make_spawn(pick_coord(), pick_coord(), pick_coord(),
                        pick_coord(), pick_coord(), pick_coord());
   endfunction

   // Fill the unused spawn fields with noise; the block must ignore them.
   function automatic pool_request_type make_tick(input logic [DT_W-1:0] dt);
      pool_request_type item;
      item         = random_spawn();
      item.command = CMD_TICK;
      item.dt      = dt;
      return item;
   endfunction

   // ---------------------------------------------------------------------
   // Channel drivers
   // ---------------------------------------------------------------------

   // Offer one request and hold it until taken. Valid stays high after the
   // handshake so back-to-back requests never drop it within one step.
   task automatic send_request(input pool_request_type item);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.command     <= item.command;
      req_chan.spawn_pos_x <= item.px;
      req_chan.spawn_pos_y <= item.py;
      req_chan.spawn_pos_z <= item.pz;
      req_chan.spawn_vel_x <= item.vx;
      req_chan.spawn_vel_y <= item.vy;
      req_chan.spawn_vel_z <= item.vz;
      req_chan.time_step   <= item.dt;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (item.command == CMD_SPAWN) spawn_into_pool(item);
      else tick_pool(item.dt);
   endtask

   // Drop valid and wait until every predicted result has come back.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Write the lifetime register; call only with the block drained.
   task automatic write_lifetime(input logic [LIFE_W-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid   <= 1'b0;
      lifetime_setting = value;
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Tick a pool that has never held anything.
   task automatic test_empty_pool();
      send_request(make_tick('0));
      send_request(make_tick(16'hFFFF));
   endtask

   // With lifetime zero a spawn lands and answers but the slot stays dead.
   task automatic test_zero_lifetime();
      drain_results();
      write_lifetime('0);
      send_request(random_spawn());
      send_request(make_tick(16'h0100));
      send_request(random_spawn());
      send_request(make_tick(16'hFFFF));
   endtask

   // Drive positions into both rails and check floor rounding of the step.
   task automatic test_saturation();
      drain_results();
      write_lifetime(LIFE_RESET);
      send_request(make_spawn(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                              32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000));
      send_request(make_spawn(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0,
                              32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1));
      send_request(make_spawn(32'sh0, 32'sh0, 32'sh0, -32'sd1, 32'sd1, -32'sd65536));
      send_request(make_spawn(32'sh7FFF_0000, -32'sd5, 32'sh8000_0001,
                              32'sh0001_0000, -32'sd3, -32'sd7));
      send_request(make_spawn(-32'sd1, 32'sh0000_FFFF, 32'sh1234_5678,
                              32'sh7FFF_FFFF, 32'sh0, 32'sh8000_0000));
      send_request(make_tick(16'hFFFF));
      send_request(make_tick('0));
      send_request(make_tick(16'h0001));
   endtask

   // A slot that runs out on a tick is moved and reported once more, then gone.
   task automatic test_expiring_slot();
      drain_results();
      write_lifetime(24'h01_0000);
      send_request(random_spawn());
      send_request(make_tick(16'hFFFF));
      send_request(make_tick(16'h0001));
      send_request(make_tick(16'h0100));
   endtask

   // Fill every slot, overflow it, tick a full pool, then tick it empty.
   task automatic test_pool_full();
      int free_slots;
      drain_results();
      write_lifetime(24'h02_0000);
      free_slots = POOL_SLOTS - live_count();
      repeat (free_slots) send_request(random_spawn());
      send_request(random_spawn());
      send_request(random_spawn());
      while (live_count() != 0) send_request(make_tick(16'hFFFF));
      send_request(random_spawn());
   endtask

   // Bursts of spawns followed by runs of ticks, with stray single requests.
   // Each phase uses its own lifetime; one phase runs with no idling at all.
   task automatic test_random_traffic();
      logic [LIFE_W-1:0] life;
      int                budget;
      int                burst;
      int unsigned       roll;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_results();
         case (phase)
            0:       life = LIFE_RESET;
            1:       life = LIFE_W'($urandom_range(1, 24'h08_0000));
            2:       life = LIFE_W'($urandom_range(0, 24'hFF_FFFF));
            default: life = 24'hFF_FFFF;
         endcase
         write_lifetime(life);
         steady_flow = (phase == 1);
         budget = RANDOM_PER_PHASE;
         while (budget > 0) begin
            roll = $urandom_range(0, 9);
            if (roll == 0) begin
               if ($urandom_range(0, 1) == 0) send_request(random_spawn());
               else send_request(make_tick(pick_step()));
               budget--;
            end else begin
               burst = $urandom_range(1, 8);
               repeat (burst) send_request(random_spawn());
               budget -= burst;
               burst = $urandom_range(1, 4);
               repeat (burst) send_request(make_tick(pick_step()));
               budget -= burst;
            end
         end
      end
      steady_flow = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------

   // Compare each accepted result with the oldest prediction.
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.kind       = rsp_chan.kind;
         got.accepted   = rsp_chan.accepted;
         got.slot_index = rsp_chan.slot_index;
         got.pos_x      = rsp_chan.out_pos_x;
         got.pos_y      = rsp_chan.out_pos_y;
         got.pos_z      = rsp_chan.out_pos_z;
         got.last       = rsp_chan.last;
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: kind=%0d acc=%0d slot=%0d last=%0d",
                        got.kind, got.accepted, got.slot_index, got.last);
         end else begin
            want = pending_results.pop_front();
            if (got.kind !== want.kind || got.accepted !== want.accepted ||
                got.slot_index !== want.slot_index || got.pos_x !== want.pos_x ||
                got.pos_y !== want.pos_y || got.pos_z !== want.pos_z ||
                got.last !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch exp kind=%0d acc=%0d slot=%0d pos=(%0d,%0d,%0d) last=%0d",
                           want.kind, want.accepted, want.slot_index,
                           want.pos_x, want.pos_y, want.pos_z, want.last);
                  $display("         got kind=%0d acc=%0d slot=%0d pos=(%0d,%0d,%0d) last=%0d",
                           got.kind, got.accepted, got.slot_index,
                           got.pos_x, got.pos_y, got.pos_z, got.last);
               end
            end
         end
      end
   end

   // Stall the result side at random; hold ready low for the stall length.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_chan.ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
   end

   // Abort when no channel has moved for too long.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------

   initial begin
      req_chan.valid       <= 1'b0;
      req_chan.command     <= CMD_SPAWN;
      req_chan.spawn_pos_x <= '0;
      req_chan.spawn_pos_y <= '0;
      req_chan.spawn_pos_z <= '0;
      req_chan.spawn_vel_x <= '0;
      req_chan.spawn_vel_y <= '0;
      req_chan.spawn_vel_z <= '0;
      req_chan.time_step   <= '0;
      csr_chan.valid       <= 1'b0;
      csr_chan.data        <= '0;

      // Start the shadow pool out of reset: register at its reset value,
      // every slot dead.
      lifetime_setting = LIFE_RESET;
      for (int i = 0; i < POOL_SLOTS; i++) begin
         life_left[i] = '0;
         pos_x_of[i]  = '0;
         pos_y_of[i]  = '0;
         pos_z_of[i]  = '0;
         vel_x_of[i]  = '0;
         vel_y_of[i]  = '0;
         vel_z_of[i]  = '0;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_empty_pool();
      test_zero_lifetime();
      test_saturation();
      test_expiring_slot();
      test_pool_full();
      test_random_traffic();

      // Drain, then give a late or extra result time to show up.
      drain_results();
      repeat (END_PAUSE) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
